FILE: hw/rtl/tqm_pkg.sv
// ----------------------------------------------------------------------------
// tqm_pkg
// Shared sizes, codes and types of the thread queue manager.
// ----------------------------------------------------------------------------
package tqm_pkg;

	localparam int unsigned NUM_THREADS = 16;
	localparam int unsigned NUM_QUEUES  = 8;

	localparam int unsigned TID_W = $clog2(NUM_THREADS);
	localparam int unsigned QID_W = $clog2(NUM_QUEUES);
	localparam int unsigned CNT_W = $clog2(NUM_THREADS + 1);

	// field widths on the stream ports
	localparam int unsigned KIND_FW   = 2;
	localparam int unsigned THREAD_FW = 4;
	localparam int unsigned QUEUE_FW  = 3;
	localparam int unsigned STATUS_FW = 2;

	localparam logic [KIND_FW-1:0] KIND_PUT = 2'd0;
	localparam logic [KIND_FW-1:0] KIND_GET = 2'd1;
	localparam logic [KIND_FW-1:0] KIND_DEL = 2'd2;

	typedef enum logic [1:0] {
		OP_PUT,
		OP_GET,
		OP_DEL,
		OP_NOP
	} op_t;

	typedef enum logic [STATUS_FW-1:0] {
		ST_OK,
		ST_QUEUED,
		ST_NOT_IN,
		ST_EMPTY
	} status_t;

	typedef struct packed {
		op_t              op;
		logic [TID_W-1:0] thread;
		logic [QID_W-1:0] queue;
	} cmd_t;

	typedef struct packed {
		logic [THREAD_FW-1:0] got_thread;
		logic                 got_valid;
		status_t              status;
	} result_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_PUT_RD,
		S_PUT_LINK,
		S_GET_RD,
		S_GET_NEXT,
		S_DEL_CMP,
		S_DEL_FIX,
		S_DEL_WR
	} state_t;

endpackage

FILE: hw/rtl/thread_queue_manager_unit.sv
// ----------------------------------------------------------------------------
// thread_queue_manager_unit
// Several FIFO queues of thread numbers kept as circular linked lists.
// ----------------------------------------------------------------------------
// Each command gives exactly one result. Commands are taken into a two-entry
// queue and executed one at a time against a link store with one write and
// one registered read per cycle. A delete walks the link store, one link a
// cycle, to find the predecessor. A refused put, a delete of a thread not in
// the named queue, a get from an empty queue and an unused kind finish in the
// dispatch state and change nothing.
module thread_queue_manager_unit import tqm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,  // thread_id[3:0], queue_id[6:4], zero[7]
	input  logic [1:0] s_axis_tuser,  // kind[1:0]
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,  // got_thread[3:0], status[5:4], zero[7:6]
	output logic       m_axis_tuser   // got_valid[0]
);

	logic    cmd_valid;
	logic    cmd_ready;
	cmd_t    cmd;
	result_t res;

	tqm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_kind   (s_axis_tuser),
		.in_thread (s_axis_tdata[3:0]),
		.in_queue  (s_axis_tdata[6:4]),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd)
	);

	tqm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.res_valid (m_axis_tvalid),
		.res_ready (m_axis_tready),
		.res       (res)
	);

	assign m_axis_tdata = {2'b00, res.status, res.got_thread};
	assign m_axis_tuser = res.got_valid;

endmodule

FILE: hw/rtl/tqm_front.sv
// ----------------------------------------------------------------------------
// tqm_front
// Accepts commands, decodes the kind and buffers them in a two-entry queue.
// ----------------------------------------------------------------------------
module tqm_front import tqm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [KIND_FW-1:0]   in_kind,
	input  logic [THREAD_FW-1:0] in_thread,
	input  logic [QUEUE_FW-1:0]  in_queue,
	output logic                 cmd_valid,
	input  logic                 cmd_ready,
	output cmd_t                 cmd
);

	localparam int unsigned CQ_DEPTH = 2;

	cmd_t       slot_q [CQ_DEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	cmd_t       dec;
	logic       push;
	logic       pop;

	always_comb begin
		dec.thread = in_thread[TID_W-1:0];
		dec.queue  = in_queue[QID_W-1:0];
		unique case (in_kind)
			KIND_PUT: dec.op = OP_PUT;
			KIND_GET: dec.op = OP_GET;
			KIND_DEL: dec.op = OP_DEL;
			default:  dec.op = OP_NOP;
		endcase
	end

	assign in_ready  = (count_q != 2'(CQ_DEPTH));
	assign cmd_valid = (count_q != 2'd0);
	assign cmd       = slot_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = cmd_valid && cmd_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: hw/rtl/tqm_back.sv
// ----------------------------------------------------------------------------
// tqm_back
// Executes queued commands on the linked-list state and holds the result.
// ----------------------------------------------------------------------------
module tqm_back import tqm_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    cmd_valid,
	output logic    cmd_ready,
	input  cmd_t    cmd,
	output logic    res_valid,
	input  logic    res_ready,
	output result_t res
);

	state_t           state_q, state_d;
	cmd_t             cur_q;
	logic [TID_W-1:0] tail_q [NUM_QUEUES];
	logic             nonempty_q [NUM_QUEUES];
	logic [QID_W-1:0] member_queue_q [NUM_THREADS];
	logic             member_valid_q [NUM_THREADS];
	logic [TID_W-1:0] link_mem [NUM_THREADS];
	logic [TID_W-1:0] link_rdata_q;
	logic [TID_W-1:0] walk_p_q;
	logic [TID_W-1:0] head_q;
	logic [CNT_W-1:0] walk_cnt_q;
	logic             out_valid_q;
	result_t          out_q;

	logic [TID_W-1:0] t;
	logic [QID_W-1:0] q;
	logic [TID_W-1:0] tail_cur;
	logic             walk_stop;

	// datapath controls
	logic             link_re;
	logic [TID_W-1:0] link_raddr;
	logic             link_we;
	logic [TID_W-1:0] link_waddr;
	logic [TID_W-1:0] link_wdata;
	logic             tail_we;
	logic [TID_W-1:0] tail_wdata;
	logic             ne_set;
	logic             ne_clr;
	logic             mbr_set;
	logic             mbr_clr;
	logic [TID_W-1:0] mbr_clr_id;
	logic             walk_start;
	logic             walk_step;
	logic             head_load;
	logic             finish;
	result_t          fin_res;

	assign t         = cur_q.thread;
	assign q         = cur_q.queue;
	assign tail_cur  = tail_q[q];
	assign walk_stop = (link_rdata_q == t) || (walk_cnt_q == CNT_W'(NUM_THREADS));
	// a command starts only with the result register empty
	assign cmd_ready = (state_q == S_IDLE) && !out_valid_q;
	assign res_valid = out_valid_q;
	assign res       = out_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (cmd_valid && cmd_ready) begin
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				unique case (cur_q.op)
					OP_PUT: begin
						if (!member_valid_q[t] && nonempty_q[q]) begin
							state_d = S_PUT_RD;
						end else begin
							state_d = S_IDLE;
						end
					end
					OP_GET: state_d = nonempty_q[q] ? S_GET_RD : S_IDLE;
					OP_DEL: begin
						if (member_valid_q[t] && member_queue_q[t] == q && nonempty_q[q]) begin
							state_d = S_DEL_CMP;
						end else begin
							state_d = S_IDLE;
						end
					end
					default: state_d = S_IDLE;
				endcase
			end
			S_PUT_RD:   state_d = S_PUT_LINK;
			S_PUT_LINK: state_d = S_IDLE;
			S_GET_RD:   state_d = (link_rdata_q == tail_cur) ? S_IDLE : S_GET_NEXT;
			S_GET_NEXT: state_d = S_IDLE;
			S_DEL_CMP:  state_d = walk_stop ? S_DEL_FIX : S_DEL_CMP;
			S_DEL_FIX:  state_d = (walk_p_q == t) ? S_IDLE : S_DEL_WR;
			S_DEL_WR:   state_d = S_IDLE;
			default:    state_d = S_IDLE;
		endcase
	end

	always_comb begin
		link_re    = 1'b0;
		link_raddr = '0;
		link_we    = 1'b0;
		link_waddr = '0;
		link_wdata = '0;
		tail_we    = 1'b0;
		tail_wdata = '0;
		ne_set     = 1'b0;
		ne_clr     = 1'b0;
		mbr_set    = 1'b0;
		mbr_clr    = 1'b0;
		mbr_clr_id = t;
		walk_start = 1'b0;
		walk_step  = 1'b0;
		head_load  = 1'b0;
		finish     = 1'b0;
		fin_res    = '{got_thread: '0, got_valid: 1'b0, status: ST_OK};
		unique case (state_q)
			S_IDLE: ;
			S_DISPATCH: begin
				unique case (cur_q.op)
					OP_PUT: begin
						if (member_valid_q[t]) begin
							finish         = 1'b1;
							fin_res.status = ST_QUEUED;
						end else if (nonempty_q[q]) begin
							link_re    = 1'b1;
							link_raddr = tail_cur;
						end else begin
							// lone thread links to itself
							link_we    = 1'b1;
							link_waddr = t;
							link_wdata = t;
							tail_we    = 1'b1;
							tail_wdata = t;
							ne_set     = 1'b1;
							mbr_set    = 1'b1;
							finish     = 1'b1;
						end
					end
					OP_GET: begin
						if (!nonempty_q[q]) begin
							finish         = 1'b1;
							fin_res.status = ST_EMPTY;
						end else begin
							link_re    = 1'b1;
							link_raddr = tail_cur;
						end
					end
					OP_DEL: begin
						if (member_valid_q[t] && member_queue_q[t] == q && nonempty_q[q]) begin
							link_re    = 1'b1;
							link_raddr = tail_cur;
							walk_start = 1'b1;
						end else begin
							finish         = 1'b1;
							fin_res.status = ST_NOT_IN;
						end
					end
					default: finish = 1'b1;
				endcase
			end
			S_PUT_RD: begin
				// new thread takes over the head link of the old tail
				link_we    = 1'b1;
				link_waddr = t;
				link_wdata = link_rdata_q;
			end
			S_PUT_LINK: begin
				link_we    = 1'b1;
				link_waddr = tail_cur;
				link_wdata = t;
				tail_we    = 1'b1;
				tail_wdata = t;
				ne_set     = 1'b1;
				mbr_set    = 1'b1;
				finish     = 1'b1;
			end
			S_GET_RD: begin
				head_load = 1'b1;
				if (link_rdata_q == tail_cur) begin
					ne_clr             = 1'b1;
					mbr_clr            = 1'b1;
					mbr_clr_id         = link_rdata_q;
					finish             = 1'b1;
					fin_res.got_thread = THREAD_FW'(link_rdata_q);
					fin_res.got_valid  = 1'b1;
				end else begin
					link_re    = 1'b1;
					link_raddr = link_rdata_q;
				end
			end
			S_GET_NEXT: begin
				link_we            = 1'b1;
				link_waddr         = tail_cur;
				link_wdata         = link_rdata_q;
				mbr_clr            = 1'b1;
				mbr_clr_id         = head_q;
				finish             = 1'b1;
				fin_res.got_thread = THREAD_FW'(head_q);
				fin_res.got_valid  = 1'b1;
			end
			S_DEL_CMP: begin
				// follow the list until the predecessor of the thread is found or the walk bound is hit
				if (!walk_stop) begin
					walk_step  = 1'b1;
					link_re    = 1'b1;
					link_raddr = link_rdata_q;
				end
			end
			S_DEL_FIX: begin
				if (walk_p_q == t) begin
					ne_clr  = 1'b1;
					mbr_clr = 1'b1;
					finish  = 1'b1;
				end else begin
					link_re    = 1'b1;
					link_raddr = t;
				end
			end
			S_DEL_WR: begin
				link_we    = 1'b1;
				link_waddr = walk_p_q;
				link_wdata = link_rdata_q;
				tail_we    = (tail_cur == t);
				tail_wdata = walk_p_q;
				mbr_clr    = 1'b1;
				finish     = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_QUEUES; i++) begin
				tail_q[i]     <= '0;
				nonempty_q[i] <= 1'b0;
			end
			for (int i = 0; i < NUM_THREADS; i++) begin
				member_queue_q[i] <= '0;
				member_valid_q[i] <= 1'b0;
			end
		end else begin
			if (tail_we) begin
				tail_q[q] <= tail_wdata;
			end
			if (ne_set) begin
				nonempty_q[q] <= 1'b1;
			end else if (ne_clr) begin
				nonempty_q[q] <= 1'b0;
			end
			if (mbr_set) begin
				member_queue_q[t] <= q;
				member_valid_q[t] <= 1'b1;
			end else if (mbr_clr) begin
				member_queue_q[mbr_clr_id] <= '0;
				member_valid_q[mbr_clr_id] <= 1'b0;
			end
		end
	end

	// link store: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (link_we) begin
			link_mem[link_waddr] <= link_wdata;
		end
		if (link_re) begin
			link_rdata_q <= link_mem[link_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready) begin
			cur_q <= cmd;
		end
		if (finish) begin
			out_q <= fin_res;
		end
		if (head_load) begin
			head_q <= link_rdata_q;
		end
		if (walk_start) begin
			walk_p_q   <= tail_cur;
			walk_cnt_q <= '0;
		end else if (walk_step) begin
			walk_p_q   <= link_rdata_q;
			walk_cnt_q <= walk_cnt_q + CNT_W'(1);
		end
	end

`ifndef SYNTHESIS
	a_busy_result_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !out_valid_q)
		else $error("result register occupied while a command runs");

	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DEL_CMP) |-> (walk_cnt_q <= CNT_W'(NUM_THREADS)))
		else $error("delete walk ran past its bound");

	a_got_unlinked: assert property (@(posedge clk) disable iff (!arst_n)
		($rose(out_valid_q) && out_q.got_valid)
			|-> !member_valid_q[out_q.got_thread[TID_W-1:0]])
		else $error("returned thread still marked as queued");

	a_finish_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		finish |=> (state_q == S_IDLE) && out_valid_q)
		else $error("command finished without posting its result");
`endif

endmodule
